// ===== sv/srpq_pkg.sv =====
`timescale 1ns / 1ps
// srpq_pkg: shared types and constants for the sorted ring priority queue
// no dependencies; imported by every module of the block except srpq_ram
package srpq_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 4;
  localparam int VAL_W = 32;
  localparam int PRI_W = 8;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic signed [VAL_W-1:0] value;
    logic [PRI_W-1:0]        priority_req;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] removed_value;
    logic [PRI_W-1:0]        removed_priority;
    logic [OCC_W-1:0]        occupancy;
  } rsp_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [PRI_W-1:0]        pri;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

endpackage

// ===== sv/srpq_ram.sv =====
`timescale 1ns / 1ps
// srpq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module srpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/srpq_out.sv =====
`timescale 1ns / 1ps
// srpq_out: result register between the sequencer and the response channel
// depends on srpq_pkg
module srpq_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  srpq_pkg::rsp_t push_data,
  output logic          free,
  output srpq_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);
  import srpq_pkg::*;

  assign free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push && free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && free) begin
      rsp <= push_data;
    end
  end

endmodule

// ===== sv/sorted_ring_priority_queue_core.sv =====
`timescale 1ns / 1ps
// sorted_ring_priority_queue_core: bounded priority queue in a ring held in one ram
// depends on srpq_pkg, srpq_ram, srpq_out
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_t {operation, value, priority_req}
//   rsp      out  rsp_valid/rsp_stall   rsp_t {status, removed_value, removed_priority,
//                                               occupancy}
//
// remove: accept, ram read, result transfer to the output register
// insert: the new entry walks from tail to head until it reaches the head or a compare
//   stops it; one ram read and one compare per position walked
// rejected insert or remove: accept, then result transfer to the output register
// rst is synchronous; empty queue after reset, no clearing pass
// req is stalled while an item is in progress; a result that meets a full, stalled
//   output register waits in the last cycle and keeps req stalled
module sorted_ring_priority_queue_core (
  input  logic           clk,
  input  logic           rst,
  input  srpq_pkg::req_t req,
  input  logic           req_valid,
  output logic           req_stall,
  output srpq_pkg::rsp_t rsp,
  output logic           rsp_valid,
  input  logic           rsp_stall
);
  import srpq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0]        state, state_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [IDX_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  cur, cur_next;
  entry_t            fresh, fresh_next;
  logic [STAT_W-1:0] pend_status, pend_status_next;
  entry_t            pend_entry, pend_entry_next;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata;
  logic              push, free;
  rsp_t              push_data;
  logic              accept;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  srpq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  srpq_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .free      (free),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  always_comb begin
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    cur_next         = cur;
    fresh_next       = fresh;
    pend_status_next = pend_status;
    pend_entry_next  = pend_entry;
    mem_we           = 1'b0;
    mem_waddr        = cur;
    mem_wdata        = fresh;
    mem_re           = 1'b0;
    mem_raddr        = ring_prev(cur);
    push             = 1'b0;
    push_data        = '{status: pend_status, removed_value: pend_entry.value,
                         removed_priority: pend_entry.pri,
                         occupancy: OCC_W'(count)};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          pend_entry_next = '0;
          if (req.operation == OP_REMOVE) begin
            if (count == '0) begin
              pend_status_next = ST_EMPTY;
              state_next       = S_PUSH;
            end else begin
              mem_re           = 1'b1;
              mem_raddr        = head;
              head_next        = ring_next(head);
              count_next       = count - 1'b1;
              pend_status_next = ST_DONE;
              state_next       = S_POP;
            end
          end else begin
            if (count == CNT_W'(DEPTH)) begin
              pend_status_next = ST_FULL;
              state_next       = S_PUSH;
            end else begin
              fresh_next       = '{value: req.value, pri: req.priority_req};
              cur_next         = tail;
              tail_next        = ring_next(tail);
              count_next       = count + 1'b1;
              pend_status_next = ST_DONE;
              state_next       = S_READ;
            end
          end
        end
      end
      S_POP: begin
        pend_entry_next = mem_rdata;
        state_next      = S_PUSH;
      end
      S_READ: begin
        // walked up to the head: the new entry lands here
        if (cur == head) begin
          mem_we     = 1'b1;
          state_next = S_PUSH;
        end else begin
          mem_re     = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        mem_we = 1'b1;
        if (fresh.pri > mem_rdata.pri) begin
          mem_wdata  = mem_rdata;
          cur_next   = ring_prev(cur);
          state_next = S_READ;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (free) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cur         <= cur_next;
    fresh       <= fresh_next;
    pend_status <= pend_status_next;
    pend_entry  <= pend_entry_next;
  end

  // occupancy bounded by the ring size
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // empty or full ring has head and tail together
  assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CNT_W'(DEPTH)) |-> head == tail)
    else $error("ring pointers out of step with count");

  // remove on an empty queue reports empty without touching the pointers
  assert property (@(posedge clk) disable iff (rst)
    (accept && req.operation == OP_REMOVE && count == '0)
      |=> (state == S_PUSH && pend_status == ST_EMPTY && $stable(head)))
    else $error("empty remove mishandled");

  // the ram is written only while placing an insert
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_READ || state == S_CMP))
    else $error("ram write outside insert walk");

endmodule

// ===== verif/sorted_ring_priority_queue_core_test.sv =====
`timescale 1ns / 1ps
// sorted_ring_priority_queue_core_test: self-checking bench for the sorted ring priority queue
// depends on srpq_pkg and sorted_ring_priority_queue_core; a scripted opening, then random traffic
module sorted_ring_priority_queue_core_test;
  import srpq_pkg::*;

  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_BATCHES = 16;
  localparam int BATCH_ITEMS    = 25;
  localparam int LONG_HOLD      = 250;
  localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
  localparam int QUIET_LIMIT    = 4000;

  typedef struct packed {
    req_t item;
    logic pinned;
    rsp_t want;
  } script_row_t;

  logic clk;
  logic rst;
  req_t req;
  logic req_valid;
  logic req_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall;

  sorted_ring_priority_queue_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  // shadow copy of the queue
  logic signed [VAL_W-1:0] shadow_value [DEPTH];
  logic [PRI_W-1:0]        shadow_pri [DEPTH];
  int                      shadow_head = 0;
  int                      shadow_tail = 0;
  int                      shadow_count = 0;

  rsp_t        awaited_results [$];
  script_row_t opening_script [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;
  bit          hold_off_pending = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic rsp_t queue_apply(input req_t item);
    rsp_t                    res;
    int                      cur;
    int                      prv;
    int                      steps;
    logic signed [VAL_W-1:0] tv;
    logic [PRI_W-1:0]        tp;
    res = '0;
    res.status = ST_DONE;
    if (item.operation == OP_INSERT) begin
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        shadow_value[shadow_tail] = item.value;
        shadow_pri[shadow_tail] = item.priority_req;
        shadow_tail = (shadow_tail + 1) % DEPTH;
        shadow_count++;
        cur = (shadow_tail + DEPTH - 1) % DEPTH;
        steps = 0;
        // bubble the newcomer headwards past strictly lower priorities
        while (shadow_count > 1 && cur != shadow_head && steps < DEPTH) begin
          prv = (cur + DEPTH - 1) % DEPTH;
          if (shadow_pri[cur] <= shadow_pri[prv]) break;
          tv = shadow_value[prv];
          tp = shadow_pri[prv];
          shadow_value[prv] = shadow_value[cur];
          shadow_pri[prv] = shadow_pri[cur];
          shadow_value[cur] = tv;
          shadow_pri[cur] = tp;
          cur = prv;
          steps++;
        end
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed_value = shadow_value[shadow_head];
        res.removed_priority = shadow_pri[shadow_head];
        shadow_head = (shadow_head + 1) % DEPTH;
        shadow_count--;
      end
    end
    res.occupancy = OCC_W'(shadow_count);
    return res;
  endfunction

  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady) return 0;
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic offer_request(input req_t item, input int gap, input logic pinned,
                               input rsp_t want);
    rsp_t predicted;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = queue_apply(item);
    awaited_results.push_back(pinned ? want : predicted);
  endtask

  function automatic req_t random_request(input int insert_pct, input int pri_mode);
    req_t item;
    item.operation = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    item.value = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: item.value = 32'h8000_0000;
        1: item.value = 32'h7fff_ffff;
        2: item.value = 32'h0000_0000;
        default: item.value = 32'hffff_ffff;
      endcase
    end
    case (pri_mode)
      0: item.priority_req = PRI_W'($urandom_range(0, 255));
      1: item.priority_req = PRI_W'($urandom_range(0, 3));
      2: item.priority_req = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: item.priority_req = PRI_W'($urandom_range(100, 103));
    endcase
    return item;
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    int len;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_stall <= 1'b0;
      end else begin
        len = idle_cycles();
        if (len == 0) begin
          rsp_stall <= 1'b0;
        end else begin
          rsp_stall <= 1'b1;
          repeat (len) @(posedge clk);
          rsp_stall <= 1'b0;
        end
      end
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result transfer with nothing outstanding");
      end else begin
        want = awaited_results.pop_front();
        if (rsp.status !== want.status)
          flag_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
        if (rsp.removed_value !== want.removed_value)
          flag_mismatch($sformatf("removed_value got %0d want %0d",
                                  rsp.removed_value, want.removed_value));
        if (rsp.removed_priority !== want.removed_priority)
          flag_mismatch($sformatf("removed_priority got %0d want %0d",
                                  rsp.removed_priority, want.removed_priority));
        if (rsp.occupancy !== want.occupancy)
          flag_mismatch($sformatf("occupancy got %0d want %0d",
                                  rsp.occupancy, want.occupancy));
      end
    end
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sorted_ring_priority_queue_core_test: errors");
      $finish;
    end
  end

  initial begin
    int   insert_pct;
    int   pri_mode;
    rsp_t none;
    none = '0;
    rst <= 1'b1;
    req <= '0;
    req_valid <= 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_value[i] = '0;
      shadow_pri[i] = '0;
    end
    opening_script = '{
      '{'{OP_REMOVE, 32'h0000_0000, 8'd0},   1'b1, '{ST_EMPTY, 32'h0, 8'd0, 4'd0}},
      '{'{OP_INSERT, 32'h8000_0000, 8'd0},   1'b1, '{ST_DONE, 32'h0, 8'd0, 4'd1}},
      '{'{OP_INSERT, 32'h7fff_ffff, 8'd255}, 1'b0, '0},
      '{'{OP_INSERT, 32'h0000_0005, 8'd255}, 1'b0, '0},
      '{'{OP_INSERT, 32'hffff_ffff, 8'd128}, 1'b0, '0},
      '{'{OP_INSERT, 32'h0000_0000, 8'd128}, 1'b0, '0},
      '{'{OP_INSERT, 32'h5555_5555, 8'd1},   1'b0, '0},
      '{'{OP_INSERT, 32'haaaa_aaaa, 8'd254}, 1'b0, '0},
      '{'{OP_INSERT, 32'h1234_5678, 8'd200}, 1'b0, '0},
      '{'{OP_INSERT, 32'h0000_0009, 8'd255}, 1'b1, '{ST_FULL, 32'h0, 8'd0, 4'd8}},
      '{'{OP_REMOVE, 32'hdead_beef, 8'd77},  1'b0, '0},
      '{'{OP_REMOVE, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_REMOVE, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_INSERT, 32'h0000_0033, 8'd255}, 1'b0, '0},
      '{'{OP_REMOVE, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_REMOVE, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_REMOVE, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_REMOVE, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_REMOVE, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_REMOVE, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_REMOVE, 32'hffff_ffff, 8'd255}, 1'b1, '{ST_EMPTY, 32'h0, 8'd0, 4'd0}},
      '{'{OP_INSERT, 32'h0000_0001, 8'd7},   1'b1, '{ST_DONE, 32'h0, 8'd0, 4'd1}},
      '{'{OP_REMOVE, 32'h0000_0000, 8'd0},   1'b1, '{ST_DONE, 32'h1, 8'd7, 4'd0}}
    };
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_script[i])
      offer_request(opening_script[i].item, idle_cycles(), opening_script[i].pinned,
                    opening_script[i].want);

    for (int b = 0; b < RANDOM_BATCHES; b++) begin
      case (b % 4)
        0: insert_pct = 85;
        1: insert_pct = 50;
        2: insert_pct = 97;
        default: insert_pct = 20;
      endcase
      pri_mode = $urandom_range(0, 3);
      // let all outstanding results drain before this batch
      if (b == 7 || b == 12) begin
        req_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
      end
      steady = (b % 5 == 2);
      // back up the result side while requests keep coming
      if (b == 3) hold_off_pending = 1'b1;
      for (int n = 0; n < BATCH_ITEMS; n++)
        offer_request(random_request(insert_pct, pri_mode),
                      (b == 3) ? 0 : idle_cycles(), 1'b0, none);
    end
    steady = 1'b0;
    req_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_ring_priority_queue_core_test: clean");
    end else begin
      $display("sorted_ring_priority_queue_core_test: errors");
    end
    $finish;
  end

endmodule
